>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Word layouts of the input and result channels, byte codes, colour table.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CELL_W   = 16;
    localparam int CUR_W    = 11;
    localparam int BYTE_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int ESC_W    = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [BYTE_W-1:0] ESC_BYTE     = 8'h1B;
    localparam logic [BYTE_W-1:0] SEL_RED      = 8'h31;
    localparam logic [BYTE_W-1:0] SEL_GREEN    = 8'h32;
    localparam logic [BYTE_W-1:0] SEL_YELLOW   = 8'h33;
    localparam logic [BYTE_W-1:0] SEL_CYAN     = 8'h36;

    localparam logic [COLOR_W-1:0] COLOR_RED    = 4'd12;
    localparam logic [COLOR_W-1:0] COLOR_GREEN  = 4'd10;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW = 4'd14;
    localparam logic [COLOR_W-1:0] COLOR_CYAN   = 4'd11;
    localparam logic [COLOR_W-1:0] COLOR_WHITE  = 4'd15;

    // escape sequence positions
    localparam logic [ESC_W-1:0] ESC_IDLE  = 3'd0;
    localparam logic [ESC_W-1:0] ESC_START = 3'd1;
    localparam logic [ESC_W-1:0] ESC_COLOR = 3'd3;
    localparam logic [ESC_W-1:0] ESC_END   = 3'd4;

    typedef struct packed {
        logic              operation;
        logic [BYTE_W-1:0] byte_value;
        logic              last_in_call;
        logic [CUR_W-1:0]  cell_index;
    } t_in_word;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [CUR_W-1:0]  cursor_position;
    } t_out_word;

    function automatic logic [COLOR_W-1:0] pick_color(input logic [BYTE_W-1:0] b);
        logic [COLOR_W-1:0] c;
        case (b)
            SEL_RED:    c = COLOR_RED;
            SEL_GREEN:  c = COLOR_GREEN;
            SEL_YELLOW: c = COLOR_YELLOW;
            SEL_CYAN:   c = COLOR_CYAN;
            default:    c = COLOR_WHITE;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/tcw_in_if.sv
// ----------------------------------------------------------------------------
// tcw_in_if: input channel of the text console writer
// Valid/ready channel carrying one terminal or read-request word.
// ----------------------------------------------------------------------------
interface tcw_in_if
    import tcw_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/tcw_out_if.sv
// ----------------------------------------------------------------------------
// tcw_out_if: result channel of the text console writer
// Valid/ready channel carrying one cell word and the hardware cursor.
// ----------------------------------------------------------------------------
interface tcw_out_if
    import tcw_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

>>> rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: terminal byte stream to text screen
// Screen cells live in one RAM; cursor, colour and escape state in registers.
// ----------------------------------------------------------------------------
// Write word: result registered in the output register (or the pending slot when
// the output is held); one word per cycle while no scroll or pending word stalls.
// Read word: RAM read data registered, then the result; no input taken meanwhile.
// A newline or wrap off the last row scrolls: one cell copied (last row: cleared)
// per cycle through the RAM read/write ports, no input taken meanwhile.
// Reset: synchronous; then the RAM is swept to zero, no input taken meanwhile.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcw_in_if.sink        i_in,
    tcw_out_if.source     o_out
);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    // one spare bit so the cell count itself is representable
    localparam int IW    = ((AW > CUR_W) ? AW : CUR_W) + 1;

    localparam logic [AW-1:0] MOVE_A    = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] LAST_A    = AW'(CELLS - 1);
    localparam logic [AW:0]   COLS_A    = (AW + 1)'(COLUMNS);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [IW-1:0] CELLS_I   = IW'(CELLS);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_FLUSH,
        S_IDLE,
        S_READ
    } t_state;

    t_state             r_state;
    logic               r_clr;
    logic [AW-1:0]      r_sc;
    logic               r_wv;
    logic               r_wcopy;
    logic [AW-1:0]      r_wdst;
    logic               r_rzero;

    logic [CW-1:0]      r_col, n_col;
    logic [RW-1:0]      r_row, n_row;
    logic [AW-1:0]      r_base, n_base;
    logic [COLOR_W-1:0] r_color, n_color;
    logic [ESC_W-1:0]   r_esc, n_esc;
    logic [CUR_W-1:0]   r_shown;

    logic               r_ov, r_pv;
    t_out_word          r_od, r_pd;

    logic               do_char, do_scroll;
    logic [AW-1:0]      cur_addr;
    logic [IW-1:0]      n_cur_ext;
    logic [IW-1:0]      idx_ext;
    logic [AW:0]        src_sum;

    logic               acc, acc_wr, acc_rd;
    logic               out_free;
    logic               res_v;
    t_out_word          res;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    assign acc    = i_in.valid && i_in.ready;
    assign acc_wr = acc && (i_in.data.operation == OP_WRITE);
    assign acc_rd = acc && (i_in.data.operation == OP_READ);

    assign i_in.ready = (r_state == S_IDLE) && !r_pv;
    assign out_free   = !r_ov || o_out.ready;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;

    assign cur_addr = r_base + AW'(r_col);
    assign idx_ext  = IW'(i_in.data.cell_index);
    assign src_sum  = {1'b0, r_sc} + COLS_A;

    // cursor, colour and escape update for one terminal byte
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_base    = r_base;
        n_color   = r_color;
        n_esc     = r_esc;
        do_char   = 1'b0;
        do_scroll = 1'b0;
        if (r_esc != ESC_IDLE) begin
            if (r_esc == ESC_COLOR) begin
                n_color = pick_color(i_in.data.byte_value);
            end
            n_esc = (r_esc >= ESC_END) ? ESC_IDLE : r_esc + ESC_W'(1);
        end else if (i_in.data.byte_value == ESC_BYTE) begin
            n_esc = ESC_START;
        end else begin
            do_char = (i_in.data.byte_value != NEWLINE_BYTE);
            if (do_char && r_col != COL_LAST) begin
                n_col = r_col + CW'(1);
            end else begin
                n_col = '0;
                if (r_row == ROW_LAST) begin
                    do_scroll = 1'b1;
                end else begin
                    n_row  = r_row + RW'(1);
                    n_base = r_base + AW'(COLUMNS);
                end
            end
        end
    end

    assign n_cur_ext = IW'(n_base) + IW'(n_col);

    always_comb begin
        res_v = 1'b0;
        res   = '0;
        if (acc_wr) begin
            res_v = 1'b1;
            res.cursor_position = i_in.data.last_in_call ? n_cur_ext[CUR_W-1:0] : r_shown;
        end else if (r_state == S_READ) begin
            res_v = 1'b1;
            res.cell_data       = r_rzero ? '0 : ram_rdata;
            res.cursor_position = r_shown;
        end
    end

    // RAM port steering: sweep writes follow their reads in the next cycle
    always_comb begin
        ram_we    = r_wv || (acc_wr && do_char);
        ram_waddr = r_wv ? r_wdst : cur_addr;
        ram_wdata = r_wv ? (r_wcopy ? ram_rdata : '0)
                         : {COLOR_W'(0), r_color, i_in.data.byte_value};
        ram_raddr = (r_state == S_SWEEP) ? src_sum[AW-1:0] : idx_ext[AW-1:0];
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_clr   <= 1'b1;
            r_sc    <= '0;
            r_wv    <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_base  <= '0;
            r_color <= COLOR_WHITE;
            r_esc   <= ESC_IDLE;
            r_shown <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_wv <= 1'b0;
            unique case (r_state)
                S_SWEEP: begin
                    r_wv    <= 1'b1;
                    r_wdst  <= r_sc;
                    r_wcopy <= !r_clr && (r_sc < MOVE_A);
                    if (r_sc == LAST_A) begin
                        r_sc    <= '0;
                        r_state <= S_FLUSH;
                    end else begin
                        r_sc <= r_sc + AW'(1);
                    end
                end
                S_FLUSH: begin
                    r_clr   <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (acc_rd) begin
                        r_rzero <= (idx_ext >= CELLS_I);
                        r_state <= S_READ;
                    end else if (acc_wr) begin
                        r_col   <= n_col;
                        r_row   <= n_row;
                        r_base  <= n_base;
                        r_color <= n_color;
                        r_esc   <= n_esc;
                        if (i_in.data.last_in_call) begin
                            r_shown <= n_cur_ext[CUR_W-1:0];
                        end
                        if (do_scroll) begin
                            r_sc    <= '0;
                            r_state <= S_SWEEP;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // output register with one pending slot behind it
            if (out_free) begin
                if (r_pv) begin
                    r_ov <= 1'b1;
                    r_od <= r_pd;
                    r_pv <= 1'b0;
                end else if (res_v) begin
                    r_ov <= 1'b1;
                    r_od <= res;
                end else begin
                    r_ov <= 1'b0;
                end
            end else if (res_v) begin
                r_pv <= 1'b1;
                r_pd <= res;
            end
        end
    end

    a_no_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wv && acc_wr))
        else $error("sweep write collides with byte write");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (IW'(cur_addr) < CELLS_I) && (r_base == AW'(r_row) * AW'(COLUMNS)))
        else $error("cursor address out of step with row/column");

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> r_ov)
        else $error("pending word without a word in the output register");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_rd |=> (r_state == S_READ) && !i_in.ready)
        else $error("read did not wait for RAM data");

    a_esc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc <= ESC_END)
        else $error("escape position beyond sequence end");

endmodule
